>>> rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared constants and codes for the min-tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  // request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_MIN  = 2'd2;
  localparam logic [1:0] REQ_LIST = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_OVER  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  typedef logic [1:0]               req_t;
  typedef logic [1:0]               sts_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage

>>> rtl/core/mts_if.sv
// ----------------------------------------------------------------------------
// mts_if
// valid/ready channels for requests and results of the min-tracking stack
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic              valid;
  logic              ready;
  mts_pkg::req_t     req_type;
  mts_pkg::data_t    push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface mts_rsp_if;
  logic              valid;
  logic              ready;
  mts_pkg::data_t    result_value;
  mts_pkg::sts_t     status;
  logic              last_of_run;

  modport source (output valid, output result_value, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_value, input status,
                  input last_of_run, output ready);
endinterface

>>> rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/min_tracking_stack.sv
// a request is taken in S_IDLE, which issues a read of both rams (registered read data);
// S_EXEC registers the result once the output register is free, and no new request is
// taken until the last result is registered; list does one ram read per entry, top to bottom
// results wait in an output register; the walk stalls while that register is full
// reset (synchronous, rst_n low) empties the stack; ram contents are not cleared
// ----------------------------------------------------------------------------
// min_tracking_stack
// bounded lifo of signed values that keeps, beside each entry, the minimum
// of that entry and everything below it
// ----------------------------------------------------------------------------
module min_tracking_stack (
  input  logic             clk,
  input  logic             rst_n,
  mts_req_if.sink          in_chan,
  mts_rsp_if.source        out_chan
);

  // sequencer states
  localparam logic S_IDLE = 1'b0;  // waiting for a request transaction
  localparam logic S_EXEC = 1'b1;  // ram data is back, produce result(s)

  logic                         state_r, state_nxt;
  logic [mts_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [mts_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  mts_pkg::req_t                req_r;
  mts_pkg::data_t               val_r;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  mts_pkg::data_t               out_value_r, out_value_nxt;
  mts_pkg::sts_t                out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  // ram ports (both stores share one read address)
  logic                         rd_en;
  logic [mts_pkg::IDX_W-1:0]    rd_addr;
  logic                         wr_en;
  logic [mts_pkg::IDX_W-1:0]    wr_addr;
  logic [mts_pkg::DATA_W-1:0]   val_rd, min_rd;
  mts_pkg::data_t               min_wr;

  logic                         accept;
  logic                         out_free;
  logic                         is_empty;
  logic                         is_full;
  logic [mts_pkg::CNT_W-1:0]    top_cnt;
  logic [mts_pkg::IDX_W-1:0]    top_idx;
  logic [mts_pkg::IDX_W-1:0]    idx_dec;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == mts_pkg::FULL_CNT);
  assign top_cnt  = count_r - 1'b1;
  assign top_idx  = top_cnt[mts_pkg::IDX_W-1:0];
  assign idx_dec  = idx_r - 1'b1;

  // running minimum for a push: new value against the minimum below it
  assign min_wr = (!is_empty && ($signed(min_rd) < val_r)) ? $signed(min_rd) : val_r;

  assign wr_addr = count_r[mts_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rd_en          = 1'b0;
    rd_addr        = top_idx;
    wr_en          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // fetch the top entry of both stores for whatever the request needs
          rd_en     = 1'b1;
          rd_addr   = top_idx;
          idx_nxt   = top_idx;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = mts_pkg::STS_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          case (req_r)
            mts_pkg::REQ_PUSH: begin
              if (is_full) begin
                out_status_nxt = mts_pkg::STS_OVER;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            mts_pkg::REQ_POP: begin
              if (is_empty) begin
                out_status_nxt = mts_pkg::STS_EMPTY;
              end else begin
                out_value_nxt = $signed(val_rd);
                count_nxt     = top_cnt;
              end
            end
            mts_pkg::REQ_MIN: begin
              if (is_empty) begin
                out_status_nxt = mts_pkg::STS_EMPTY;
              end else begin
                out_value_nxt = $signed(min_rd);
              end
            end
            default: begin
              // list: one entry per cycle while the output register is free, next read issued alongside
              if (is_empty) begin
                out_status_nxt = mts_pkg::STS_EMPTY;
              end else begin
                out_value_nxt = $signed(val_rd);
                if (idx_r != '0) begin
                  out_last_nxt = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = idx_dec;
                  idx_nxt      = idx_dec;
                  state_nxt    = S_EXEC;
                end
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      req_r <= in_chan.req_type;
      val_r <= in_chan.push_value;
    end
  end

  // value store
  mts_ram #(
    .WIDTH (mts_pkg::DATA_W),
    .DEPTH (mts_pkg::STACK_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (val_rd)
  );

  // minimum store
  mts_ram #(
    .WIDTH (mts_pkg::DATA_W),
    .DEPTH (mts_pkg::STACK_DEPTH)
  ) u_min_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (min_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (min_rd)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.last_of_run  = out_last_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min-tracking stack: a short table of directed
// requests, then biased random fill/drain traffic; every result transaction
// is checked against an in-bench model of the stack
// ----------------------------------------------------------------------------
module tb_top;

  typedef mts_pkg::req_t  req_t;
  typedef mts_pkg::sts_t  sts_t;
  typedef mts_pkg::data_t data_t;

  // run shape
  localparam int N_RANDOM     = 425;   // random requests after the table
  localparam int CALM_ITEMS   = 60;    // trailing requests with no idling
  localparam int HOLD_AT      = 150;   // random index where the long hold-off starts
  localparam int HOLD_CYCLES  = 64;    // receiver hold-off length
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 24;    // quiet cycles after the last expected result

  // one result transaction as the bench expects it
  typedef struct {
    data_t value;
    sts_t  status;
    logic  last;
  } result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    req_t  req;
    data_t value;
    bit    typed;
    data_t exp_value;
    sts_t  exp_status;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mts_req_if req_ch ();
  mts_rsp_if rsp_ch ();

  min_tracking_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  // shadow copy of the stack contents and its running minimum column
  data_t shadow_vals [mts_pkg::STACK_DEPTH];
  data_t shadow_mins [mts_pkg::STACK_DEPTH];
  int    shadow_count;

  result_t   expected_results [$];
  stim_row_t directed_rows [$];

  int errors;
  int stall_cycles;
  bit calm;           // no idling on either side
  bit draining;       // random traffic biased toward pops
  bit hold_request;   // sender asks the receiver for its long hold-off
  bit hold_done;
  bit rx_holding;     // receiver is in the long hold-off

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // stack model: queues every result one request causes
  // --------------------------------------------------------------------------
  function automatic void stack_predict(input req_t r, input data_t v);
    result_t res;
    data_t   m;
    res.value  = '0;
    res.status = mts_pkg::STS_OK;
    res.last   = 1'b1;
    if (r == mts_pkg::REQ_PUSH) begin
      if (shadow_count >= mts_pkg::STACK_DEPTH) begin
        // full: stack untouched, overflow reported
        res.status = mts_pkg::STS_OVER;
      end else begin
        m = v;
        if (shadow_count > 0 && shadow_mins[shadow_count-1] < v)
          m = shadow_mins[shadow_count-1];
        shadow_vals[shadow_count] = v;
        shadow_mins[shadow_count] = m;
        shadow_count++;
      end
      expected_results.push_back(res);
    end else if (shadow_count == 0) begin
      // pop, minimum and list all answer empty on an empty stack
      res.status = mts_pkg::STS_EMPTY;
      expected_results.push_back(res);
    end else if (r == mts_pkg::REQ_POP) begin
      shadow_count--;
      res.value = shadow_vals[shadow_count];
      expected_results.push_back(res);
    end else if (r == mts_pkg::REQ_MIN) begin
      // minimum always from the current top of the minimum column
      res.value = shadow_mins[shadow_count-1];
      expected_results.push_back(res);
    end else begin
      // list walks top to bottom, last flag only on the bottom entry
      for (int i = shadow_count - 1; i >= 0; i--) begin
        res.value = shadow_vals[i];
        res.last  = (i == 0);
        expected_results.push_back(res);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offer one request, wait for its transaction, then maybe idle for a burst
  task automatic send_request(input req_t r, input data_t v, input bit typed,
                              input data_t ev, input sts_t es);
    result_t hand;
    int      gap;
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r;
    req_ch.push_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // transaction taken at this edge
    stack_predict(r, v);
    if (typed) begin
      // hand-written rows are single-result requests
      hand.value  = ev;
      hand.status = es;
      hand.last   = 1'b1;
      expected_results[expected_results.size()-1] = hand;
    end
    // random idle burst, never while the receiver is holding off
    if (!calm && !rx_holding && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_row(input req_t r, input data_t v, input bit typed,
                         input data_t ev, input sts_t es);
    stim_row_t row;
    row.req        = r;
    row.value      = v;
    row.typed      = typed;
    row.exp_value  = ev;
    row.exp_status = es;
    directed_rows.push_back(row);
  endtask

  // values lean toward the extremes and toward ties around zero
  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return data_t'(32'h7fff_ffff);
      1:       return data_t'(32'h8000_0000);
      2:       return data_t'($urandom_range(0, 20)) - data_t'(10);
      3:       return data_t'(-1);
      default: return data_t'($urandom);
    endcase
  endfunction

  // fill mode mostly pushes, drain mode mostly pops; a tenth is plain noise
  function automatic req_t pick_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0:       return mts_pkg::REQ_PUSH;
        1:       return mts_pkg::REQ_POP;
        2:       return mts_pkg::REQ_MIN;
        default: return mts_pkg::REQ_LIST;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (draining) begin
      if (roll < 15) return mts_pkg::REQ_PUSH;
      if (roll < 75) return mts_pkg::REQ_POP;
      if (roll < 87) return mts_pkg::REQ_MIN;
      return mts_pkg::REQ_LIST;
    end else begin
      if (roll < 60) return mts_pkg::REQ_PUSH;
      if (roll < 75) return mts_pkg::REQ_POP;
      if (roll < 87) return mts_pkg::REQ_MIN;
      return mts_pkg::REQ_LIST;
    end
  endfunction

  initial begin
    req_t  r;
    data_t v;
    errors       = 0;
    shadow_count = 0;
    calm         = 1'b0;
    draining     = 1'b0;
    hold_request = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= mts_pkg::REQ_PUSH;
    req_ch.push_value <= '0;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    // empty stack: every read-type request answers empty
    add_row(mts_pkg::REQ_POP,  '0, 1'b1, '0, mts_pkg::STS_EMPTY);
    add_row(mts_pkg::REQ_MIN,  '0, 1'b1, '0, mts_pkg::STS_EMPTY);
    add_row(mts_pkg::REQ_LIST, '0, 1'b1, '0, mts_pkg::STS_EMPTY);
    // extremes of the value range
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h7fff_ffff), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h8000_0000), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_MIN,  '0, 1'b1, data_t'(32'h8000_0000), mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(0),  1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(-1), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_LIST, '0, 1'b0, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_POP,  '0, 1'b1, data_t'(-1), mts_pkg::STS_OK);
    // fill to full with varied bit patterns
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h5555_5555), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'haaaa_aaaa), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h0000_0001), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'hffff_fffe), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h8000_0001), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h7fff_fffe), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h0f0f_0f0f), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'hf0f0_f0f0), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h8000_0000), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h1234_5678), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'hedcb_a987), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h0000_ffff), 1'b1, '0, mts_pkg::STS_OK);
    add_row(mts_pkg::REQ_PUSH, data_t'(32'hffff_0000), 1'b1, '0, mts_pkg::STS_OK);
    // push onto a full stack, then list all sixteen entries
    add_row(mts_pkg::REQ_PUSH, data_t'(32'h0bad_0bad), 1'b1, '0, mts_pkg::STS_OVER);
    add_row(mts_pkg::REQ_LIST, '0, 1'b0, '0, mts_pkg::STS_OK);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].exp_value, directed_rows[i].exp_status);

    // random traffic, switching between fill and drain at the stack limits
    draining = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_AT)
        hold_request = 1'b1;
      if (n == N_RANDOM - CALM_ITEMS)
        calm = 1'b1;
      if (shadow_count == mts_pkg::STACK_DEPTH && $urandom_range(0, 2) == 0)
        draining = 1'b1;
      else if (shadow_count == 0 && $urandom_range(0, 2) == 0)
        draining = 1'b0;
      r = pick_request();
      v = pick_value();
      send_request(r, v, 1'b0, '0, mts_pkg::STS_OK);
    end
    req_ch.valid <= 1'b0;

    // let every outstanding result arrive, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: check each transaction, drive ready with bursts and one
  // long hold-off that lets the block back up into its input
  // --------------------------------------------------------------------------
  int idle_left;
  int hold_left;

  initial begin
    result_t exp_res;
    idle_left  = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    rx_holding = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: value=%0d status=%0d last=%0b",
                   $time, rsp_ch.result_value, rsp_ch.status, rsp_ch.last_of_run);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (rsp_ch.result_value !== exp_res.value || rsp_ch.status !== exp_res.status ||
              rsp_ch.last_of_run !== exp_res.last) begin
            $display("%0t mismatch: exp v=%0d s=%0d l=%0b, act v=%0d s=%0d l=%0b",
                     $time, exp_res.value, exp_res.status, exp_res.last,
                     rsp_ch.result_value, rsp_ch.status, rsp_ch.last_of_run);
            errors++;
          end
        end
      end

      // ready for the next cycle
      if (hold_left > 0) begin
        hold_left--;
        rx_holding = (hold_left > 0);
        rsp_ch.ready <= (hold_left == 0);
      end else if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        rx_holding = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rsp_ch.ready <= (idle_left == 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 6) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no transaction on either channel
  // --------------------------------------------------------------------------
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
